/* rtl/spectral_whiten_autogain_hold_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the spectral whitening core
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_WHITEN_AUTOGAIN_HOLD_CORE_DEFINES_SVH
`define SPECTRAL_WHITEN_AUTOGAIN_HOLD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SWAH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swah assertion failed");
`define SWAH_ASSERT_NEVER(label, clk, rst_n, cond) \
    `SWAH_ASSERT(label, clk, rst_n, !(cond))
`else
`define SWAH_ASSERT(label, clk, rst_n, prop)
`define SWAH_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* rtl/swah_pkg.sv */
// ----------------------------------------------------------------------------
// swah_pkg
// Shared constants, types and helpers of the spectral whitening core.
// ----------------------------------------------------------------------------
`default_nettype none

package swah_pkg;

    localparam int BINS_DEFAULT = 512;

    localparam int MAG_W       = 24;
    localparam int FACTOR_W    = 17;
    localparam int BIN_INDEX_W = 9;
    localparam int LEVEL_W     = 24;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH_SPEED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY        = 2'd1;

    localparam logic [FACTOR_W-1:0] ONE_Q16      = 17'd65536;
    localparam logic [FACTOR_W-1:0] SMOOTH_RESET = 17'd3277;
    localparam logic [FACTOR_W-1:0] DECAY_RESET  = 17'd62259;
    localparam logic [MAG_W-1:0]    PEAK_RESET   = 24'd65536;
    localparam logic [MAG_W-1:0]    MAX24        = 24'hFFFFFF;

    // Divider: quotient bits resolved per cycle and resulting step count.
    localparam int QUOT_W    = 24;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = QUOT_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_MIXAVG,
        B_DIFF,
        B_DIVSET,
        B_DIV,
        B_HOLD,
        B_WRITE,
        B_PEAK,
        B_PEAKW
    } back_state_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [LEVEL_W-1:0]     level;
        logic                   last;
    } result_t;

    function automatic logic [FACTOR_W-1:0] sat_factor(input logic [FACTOR_W-1:0] f);
        return (f > ONE_Q16) ? ONE_Q16 : f;
    endfunction

endpackage

`default_nettype wire

/* rtl/spectral_whiten_autogain_hold_core.sv */
// ----------------------------------------------------------------------------
// spectral_whiten_autogain_hold_core
// Spectral whitening with auto gain and decaying per-bin peak hold.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word contents
//  -------   ---------  -------------------  --------------------------------
//  input     in         push / full          magnitude, frame_end
//  result    out        empty / pop          bin_index, level, last
//  config    in         cfg_write            cfg_index, cfg_data
//
// In the back end a bin goes through one store read, the averaging
// multiply, the difference, divider setup, six divider steps (four quotient
// bits each) and the hold multiply and write-back. A bin whose quotient
// saturates skips the divider. The last bin of a frame adds the smoothed
// peak update on the shared multiplier.
// After reset the two bin stores are swept to zero, one entry per cycle;
// full stays high meanwhile, configuration writes are still taken.
// Two-word queues on the input and result sides let either side stall without
// stopping the other.
//
`default_nettype none

module spectral_whiten_autogain_hold_core #(
    parameter int BINS = swah_pkg::BINS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic [swah_pkg::MAG_W-1:0]            magnitude,
    input  wire logic                                  frame_end,

    output logic                                       empty,
    input  wire logic                                  pop,
    output logic      [swah_pkg::BIN_INDEX_W-1:0]      bin_index,
    output logic      [swah_pkg::LEVEL_W-1:0]          level,
    output logic                                       last,

    input  wire logic                                  cfg_write,
    input  wire logic [swah_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  wire logic [swah_pkg::FACTOR_W-1:0]         cfg_data
);

    localparam int IDX_W  = $clog2(BINS);
    localparam int ITEM_W = swah_pkg::MAG_W + 1 + IDX_W;

    // Configuration registers. Values above one are clamped where they are used.
    logic [swah_pkg::FACTOR_W-1:0] smooth_speed_reg;
    logic [swah_pkg::FACTOR_W-1:0] decay_reg;

    swah_pkg::back_status_t status;
    logic                   item_pop;
    logic                   item_empty;
    logic [ITEM_W-1:0]      item_data;
    logic                   out_full;
    logic                   out_push;
    swah_pkg::result_t      out_data;
    swah_pkg::result_t      res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_speed_reg <= swah_pkg::SMOOTH_RESET;
            decay_reg        <= swah_pkg::DECAY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                swah_pkg::REG_SMOOTH_SPEED:
                begin
                    smooth_speed_reg <= cfg_data;
                end
                swah_pkg::REG_DECAY:
                begin
                    decay_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The front end numbers bins and queues them; the back end owns all
    // per-bin and per-frame arithmetic state.
    swah_front #(
        .BINS (BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .magnitude  (magnitude),
        .frame_end  (frame_end),
        .status     (status),
        .item_pop   (item_pop),
        .item_empty (item_empty),
        .item_data  (item_data)
    );

    swah_back #(
        .BINS (BINS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .smooth_speed (smooth_speed_reg),
        .decay        (decay_reg),
        .item_empty   (item_empty),
        .item_data    (item_data),
        .item_pop     (item_pop),
        .out_full     (out_full),
        .out_push     (out_push),
        .out_data     (out_data),
        .status       (status)
    );

    // Result queue: the oldest finished word sits on the ports until popped.
    swah_fifo #(
        .WIDTH ($bits(swah_pkg::result_t))
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign bin_index = res_head.bin_index;
    assign level     = res_head.level;
    assign last      = res_head.last;

endmodule

`default_nettype wire

/* rtl/swah_fifo.sv */
// ----------------------------------------------------------------------------
// swah_fifo
// Two-entry word queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module swah_fifo #(
    parameter int WIDTH = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/swah_front.sv */
// ----------------------------------------------------------------------------
// swah_front
// Accepts input words, tags each with its bin position and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module swah_front #(
    parameter int BINS = swah_pkg::BINS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic [swah_pkg::MAG_W-1:0]             magnitude,
    input  wire logic                                   frame_end,
    input  wire swah_pkg::back_status_t                 status,
    input  wire logic                                   item_pop,
    output logic                                        item_empty,
    output logic [swah_pkg::MAG_W+$clog2(BINS):0]       item_data
);

    localparam int IDX_W  = $clog2(BINS);
    localparam int ITEM_W = swah_pkg::MAG_W + 1 + IDX_W;

    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    logic              q_full;
    logic              accept;
    logic [ITEM_W-1:0] item_in;

    // No words are taken while the back end sweeps its bin stores.
    assign full    = q_full || status.clearing;
    assign accept  = push && !full;
    assign item_in = {magnitude, frame_end, cnt_reg};

    always_comb
    begin
        if (frame_end || (cnt_reg == IDX_W'(BINS - 1)))
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    swah_fifo #(
        .WIDTH (ITEM_W)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (item_in),
        .full  (q_full),
        .pop   (item_pop),
        .rdata (item_data),
        .empty (item_empty)
    );

endmodule

`default_nettype wire

/* rtl/swah_back.sv */
// ----------------------------------------------------------------------------
// swah_back
// Per-bin engine: average, difference, divide, peak hold and peak update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spectral_whiten_autogain_hold_core_defines.svh"

module swah_back #(
    parameter int BINS = swah_pkg::BINS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [swah_pkg::FACTOR_W-1:0]        smooth_speed,
    input  wire logic [swah_pkg::FACTOR_W-1:0]        decay,
    input  wire logic                                 item_empty,
    input  wire logic [swah_pkg::MAG_W+$clog2(BINS):0] item_data,
    output logic                                      item_pop,
    input  wire logic                                 out_full,
    output logic                                      out_push,
    output swah_pkg::result_t                         out_data,
    output swah_pkg::back_status_t                    status
);

    localparam int IDX_W  = $clog2(BINS);
    localparam int ITEM_W = swah_pkg::MAG_W + 1 + IDX_W;
    localparam int WIDE_W = (IDX_W > swah_pkg::BIN_INDEX_W) ? IDX_W : swah_pkg::BIN_INDEX_W;
    localparam int MAG_W  = swah_pkg::MAG_W;
    localparam int Q_W    = swah_pkg::QUOT_W;

    swah_pkg::back_state_t state_reg;
    swah_pkg::back_state_t state_next;

    // Bin stores and their registered read data.
    logic [MAG_W-1:0] avg_mem  [BINS];
    logic [MAG_W-1:0] held_mem [BINS];
    logic [MAG_W-1:0] avg_rd_reg;
    logic [MAG_W-1:0] held_rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    logic [MAG_W-1:0] avg_wdata;
    logic [MAG_W-1:0] held_wdata;

    // Current bin.
    logic [MAG_W-1:0] mag_reg;
    logic             end_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [MAG_W-1:0] item_mag;
    logic             item_end;
    logic [IDX_W-1:0] item_idx;

    // Frame state.
    logic [MAG_W-1:0] sp_reg;
    logic [MAG_W-1:0] fp_reg;
    logic [IDX_W-1:0] clr_reg;

    // Datapath.
    logic signed [24:0] mul_a;
    logic [swah_pkg::FACTOR_W-1:0] mul_b;
    logic signed [42:0] prod_next;
    logic signed [42:0] prod_reg;
    logic signed [42:0] prod_rnd;
    logic [MAG_W-1:0]   mix_base;
    logic signed [26:0] mix_sum;
    logic [MAG_W-1:0]   avg_reg;
    logic signed [24:0] d_reg;
    logic signed [24:0] d_next;
    logic [24:0]        d_abs;
    logic [MAG_W-1:0]   absd;
    logic               q_ovf;
    logic [MAG_W-1:0]   held_max;
    logic [MAG_W-1:0]   held_new;
    logic [swah_pkg::FACTOR_W-1:0] s_sat;
    logic [swah_pkg::FACTOR_W-1:0] dk_sat;

    // Divider.
    logic [Q_W-1:0]   rem_reg;
    logic [Q_W-1:0]   dlo_reg;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   rem_step;
    logic [Q_W-1:0]   dlo_step;
    logic [Q_W-1:0]   q_step;
    logic [swah_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [WIDE_W-1:0] idx_wide;

    assign item_mag = item_data[ITEM_W-1 -: MAG_W];
    assign item_end = item_data[IDX_W];
    assign item_idx = item_data[IDX_W-1:0];

    assign s_sat  = swah_pkg::sat_factor(smooth_speed);
    assign dk_sat = swah_pkg::sat_factor(decay);

    // ------------------------------------------------------------------
    // Shared multiplier: one signed 25 x unsigned 17 product per cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            // The hold product is kept while the write waits on a full queue.
            swah_pkg::B_HOLD, swah_pkg::B_WRITE:
            begin
                mul_a = $signed({1'b0, held_max});
                mul_b = dk_sat;
            end
            swah_pkg::B_PEAK:
            begin
                mul_a = $signed({1'b0, fp_reg}) - $signed({1'b0, sp_reg});
                mul_b = s_sat;
            end
            default:
            begin
                mul_a = $signed({1'b0, mag_reg}) - $signed({1'b0, avg_rd_reg});
                mul_b = s_sat;
            end
        endcase
    end

    assign prod_next = mul_a * $signed({1'b0, mul_b});
    assign prod_rnd  = prod_reg + 43'sd32768;

    // A mix toward b by s equals a plus the rounded scaled difference.
    assign mix_base = (state_reg == swah_pkg::B_PEAKW) ? sp_reg : avg_rd_reg;
    assign mix_sum  = $signed({3'b000, mix_base}) + $signed(prod_rnd[42:16]);
    assign d_next   = $signed({1'b0, mag_reg}) - $signed({1'b0, mix_sum[MAG_W-1:0]});
    assign held_new = prod_rnd[39:16];

    assign d_abs    = d_reg[24] ? 25'(-d_reg) : d_reg;
    assign absd     = d_abs[MAG_W-1:0];
    // Quotient reaches 2^24 exactly when |d| >= peak * 256; a zero peak lands here too.
    assign q_ovf    = ({8'b0, absd} >= {sp_reg, 8'b0});
    assign held_max = (q_reg > held_rd_reg) ? q_reg : held_rd_reg;

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        logic [Q_W:0]   t;
        logic [Q_W-1:0] r;
        logic [Q_W-1:0] dl;
        logic [Q_W-1:0] qv;
        r  = rem_reg;
        dl = dlo_reg;
        qv = q_reg;
        for (int i = 0; i < swah_pkg::DIV_BITS; i++)
        begin
            t = {r, dl[Q_W-1]};
            if (t >= {1'b0, sp_reg})
            begin
                r  = Q_W'(t - {1'b0, sp_reg});
                qv = {qv[Q_W-2:0], 1'b1};
            end
            else
            begin
                r  = t[Q_W-1:0];
                qv = {qv[Q_W-2:0], 1'b0};
            end
            dl = {dl[Q_W-2:0], 1'b0};
        end
        rem_step = r;
        dlo_step = dl;
        q_step   = qv;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and control outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        out_push   = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = idx_reg;
        avg_wdata  = avg_reg;
        held_wdata = held_new;
        case (state_reg)
            swah_pkg::B_CLEAR:
            begin
                mem_we     = 1'b1;
                wr_addr    = clr_reg;
                avg_wdata  = '0;
                held_wdata = '0;
                if (clr_reg == IDX_W'(BINS - 1))
                begin
                    state_next = swah_pkg::B_IDLE;
                end
            end
            swah_pkg::B_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop   = 1'b1;
                    state_next = swah_pkg::B_MIXAVG;
                end
            end
            swah_pkg::B_MIXAVG:
            begin
                state_next = swah_pkg::B_DIFF;
            end
            swah_pkg::B_DIFF:
            begin
                state_next = swah_pkg::B_DIVSET;
            end
            swah_pkg::B_DIVSET:
            begin
                state_next = q_ovf ? swah_pkg::B_HOLD : swah_pkg::B_DIV;
            end
            swah_pkg::B_DIV:
            begin
                if (div_cnt_reg == swah_pkg::DIV_CNT_W'(swah_pkg::DIV_STEPS - 1))
                begin
                    state_next = swah_pkg::B_HOLD;
                end
            end
            swah_pkg::B_HOLD:
            begin
                state_next = swah_pkg::B_WRITE;
            end
            swah_pkg::B_WRITE:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    mem_we     = 1'b1;
                    state_next = end_reg ? swah_pkg::B_PEAK : swah_pkg::B_IDLE;
                end
            end
            swah_pkg::B_PEAK:
            begin
                state_next = swah_pkg::B_PEAKW;
            end
            swah_pkg::B_PEAKW:
            begin
                state_next = swah_pkg::B_IDLE;
            end
            default:
            begin
                state_next = swah_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swah_pkg::B_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            div_cnt_reg <= '0;
            sp_reg      <= swah_pkg::PEAK_RESET;
            fp_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                swah_pkg::B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                swah_pkg::B_DIVSET:
                begin
                    div_cnt_reg <= '0;
                    if (d_reg > $signed({1'b0, fp_reg}))
                    begin
                        fp_reg <= d_reg[MAG_W-1:0];
                    end
                end
                swah_pkg::B_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                swah_pkg::B_PEAKW:
                begin
                    sp_reg <= mix_sum[MAG_W-1:0];
                    fp_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (item_pop)
        begin
            mag_reg <= item_mag;
            end_reg <= item_end;
            idx_reg <= item_idx;
        end
        if (state_reg == swah_pkg::B_DIFF)
        begin
            avg_reg <= mix_sum[MAG_W-1:0];
            d_reg   <= d_next;
        end
        if (state_reg == swah_pkg::B_DIVSET)
        begin
            rem_reg <= Q_W'(absd[MAG_W-1:8]);
            dlo_reg <= {absd[7:0], 16'b0};
            q_reg   <= q_ovf ? swah_pkg::MAX24 : '0;
        end
        if (state_reg == swah_pkg::B_DIV)
        begin
            rem_reg <= rem_step;
            dlo_reg <= dlo_step;
            q_reg   <= q_step;
        end
    end

    // Bin stores.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            avg_mem[wr_addr]  <= avg_wdata;
            held_mem[wr_addr] <= held_wdata;
        end
        if (item_pop)
        begin
            avg_rd_reg  <= avg_mem[item_idx];
            held_rd_reg <= held_mem[item_idx];
        end
    end

    assign idx_wide           = WIDE_W'(idx_reg);
    assign out_data.bin_index = idx_wide[swah_pkg::BIN_INDEX_W-1:0];
    assign out_data.level     = held_new;
    assign out_data.last      = end_reg;

    assign status.clearing = (state_reg == swah_pkg::B_CLEAR);

    `SWAH_ASSERT_NEVER(a_no_result_in_clear, clk, rst_n,
        (state_reg == swah_pkg::B_CLEAR) && (out_push || item_pop))
    `SWAH_ASSERT(a_after_write, clk, rst_n,
        out_push |=> (state_reg == swah_pkg::B_PEAK) || (state_reg == swah_pkg::B_IDLE))
    `SWAH_ASSERT(a_peak_only_at_frame_end, clk, rst_n,
        (state_reg != swah_pkg::B_PEAKW) |=> $stable(sp_reg))
    `SWAH_ASSERT(a_peak_follows_last, clk, rst_n,
        (state_reg == swah_pkg::B_PEAK) |-> $past(out_push) && end_reg)
    `SWAH_ASSERT(a_div_count_bound, clk, rst_n,
        (state_reg == swah_pkg::B_DIV) |->
            (div_cnt_reg <= swah_pkg::DIV_CNT_W'(swah_pkg::DIV_STEPS - 1)))

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: spectral whitening core testbench
// Drives spectrum bins through the push/full queue, keeps a bit-exact model
// of the per-bin averages, held levels and auto-gain peak, and checks every
// result word popped from the block against it, under random idling, a long
// receiver stall and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int BIN_COUNT     = swah_pkg::BINS_DEFAULT;
    // Margin for the back end to finish its last bin, the frame end included.
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASE_ITEMS   = 310;
    localparam int ITEMS_PER_CFG = 150;

    // The block decodes two of the four register indexes; the others must be
    // ignored.
    localparam logic [swah_pkg::CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [swah_pkg::CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             push;
    logic                             full;
    logic [swah_pkg::MAG_W-1:0]       magnitude;
    logic                             frame_end;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [swah_pkg::BIN_INDEX_W-1:0] bin_index;
    logic [swah_pkg::LEVEL_W-1:0]     level;
    logic                             last;
    logic                             cfg_write;
    logic [swah_pkg::CFG_ADDR_W-1:0]  cfg_index;
    logic [swah_pkg::FACTOR_W-1:0]    cfg_data;

    // Model state: a private copy of everything the block keeps.
    logic [swah_pkg::FACTOR_W-1:0]    speed_reg;
    logic [swah_pkg::FACTOR_W-1:0]    decay_reg;
    logic [swah_pkg::MAG_W-1:0]       avg_mem [BIN_COUNT];
    logic [swah_pkg::LEVEL_W-1:0]     held_mem [BIN_COUNT];
    logic [swah_pkg::MAG_W-1:0]       smoothed_peak;
    logic [swah_pkg::MAG_W-1:0]       frame_peak;
    logic [swah_pkg::BIN_INDEX_W-1:0] bin_count;

    // Result words still owed by the block, oldest first.
    swah_pkg::result_t                pending_levels [$];
    int                               mismatch_count = 0;
    int                               cycle_count = 0;

    // Idling knobs. The sender's is used only by the stimulus process; the
    // receiver's is updated with nonblocking writes because the receiver
    // process reads it on the same clock edge.
    int                               send_idle_pct = 0;
    int                               recv_idle_pct = 0;

    // A long receiver stall is requested by bumping the token; the receiver
    // process notices it on the following falling edge and counts it down.
    int                               stall_token = 0;
    int                               stall_len = 0;
    int                               stall_seen = 0;
    int                               stall_left = 0;

    always #2 clk = ~clk;

    spectral_whiten_autogain_hold_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .magnitude (magnitude),
        .frame_end (frame_end),
        .empty     (empty),
        .pop       (pop),
        .bin_index (bin_index),
        .level     (level),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Rounded Q1.16 blend from one value toward another; the result always
    // lies between the two, so it fits the 24-bit field.
    function automatic logic [swah_pkg::MAG_W-1:0] blend_q16(
        input logic [swah_pkg::MAG_W-1:0]    from_val,
        input logic [swah_pkg::MAG_W-1:0]    to_val,
        input logic [swah_pkg::FACTOR_W-1:0] frac);
        logic [47:0] acc;
        acc = 48'(from_val) * 48'(swah_pkg::ONE_Q16 - frac) + 48'(to_val) * 48'(frac)
            + 48'd32768;
        return acc[39:16];
    endfunction

    // Processes one accepted bin through the model and returns the word the
    // block must produce for it.
    function automatic swah_pkg::result_t whiten_bin(input logic [swah_pkg::MAG_W-1:0] mag,
                                                     input logic fe);
        logic [swah_pkg::FACTOR_W-1:0]    s;
        logic [swah_pkg::FACTOR_W-1:0]    dk;
        logic [swah_pkg::BIN_INDEX_W-1:0] idx;
        logic [swah_pkg::MAG_W-1:0]       avg;
        logic [swah_pkg::MAG_W-1:0]       absd;
        logic [swah_pkg::LEVEL_W-1:0]     quot;
        logic [swah_pkg::LEVEL_W-1:0]     hold;
        logic signed [25:0]               diff;
        logic [39:0]                      scaled;
        logic [40:0]                      prod;
        swah_pkg::result_t                word;
        // Factors above one count as exactly one.
        s   = (speed_reg > swah_pkg::ONE_Q16) ? swah_pkg::ONE_Q16 : speed_reg;
        dk  = (decay_reg > swah_pkg::ONE_Q16) ? swah_pkg::ONE_Q16 : decay_reg;
        idx = bin_count;

        avg = blend_q16(avg_mem[idx], mag, s);
        avg_mem[idx] = avg;

        diff = $signed({2'b00, mag}) - $signed({2'b00, avg});
        if (diff > $signed({2'b00, frame_peak}))
            frame_peak = diff[23:0];
        absd = (diff < 0) ? 24'(-diff) : diff[23:0];

        // A zero gain reference and an oversized quotient both saturate.
        if (smoothed_peak == '0)
            quot = swah_pkg::MAX24;
        else
        begin
            scaled = {absd, 16'h0000} / 40'(smoothed_peak);
            quot = (scaled > 40'(swah_pkg::MAX24)) ? swah_pkg::MAX24 : scaled[23:0];
        end

        hold = held_mem[idx];
        if (quot > hold)
            hold = quot;
        prod = 41'(hold) * 41'(dk) + 41'd32768;
        hold = prod[39:16];
        held_mem[idx] = hold;

        word.bin_index = idx;
        word.level     = hold;
        word.last      = fe;

        if (fe)
        begin
            smoothed_peak = blend_q16(smoothed_peak, frame_peak, s);
            frame_peak = '0;
            bin_count = '0;
        end
        else
        begin
            // Nine bits hold exactly one frame of bins, so an open frame wraps.
            bin_count = bin_count + 1'b1;
        end
        return word;
    endfunction

    function automatic logic [swah_pkg::MAG_W-1:0] pick_magnitude();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return swah_pkg::MAX24;
            2:       return swah_pkg::MAG_W'($urandom_range(0, 255));
            3, 4:    return swah_pkg::MAG_W'($urandom_range(0, 131072));
            default: return swah_pkg::MAG_W'($urandom);
        endcase
    endfunction

    // Mostly the interesting corners, with values past one to check the clamp.
    function automatic logic [swah_pkg::FACTOR_W-1:0] pick_factor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 17'd1;
            2:       return 17'd65535;
            3:       return swah_pkg::ONE_Q16;
            4:       return swah_pkg::FACTOR_W'($urandom_range(65537, 131071));
            5:       return swah_pkg::SMOOTH_RESET;
            6:       return swah_pkg::DECAY_RESET;
            default: return swah_pkg::FACTOR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Offers one bin word and returns on the falling edge after it was taken,
    // with push still high so that back-to-back words need no gap.
    task automatic send_bin(input logic [swah_pkg::MAG_W-1:0] mag, input logic fe);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        magnitude <= mag;
        frame_end <= fe;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_levels.push_back(whiten_bin(mag, fe));
        @(negedge clk);
    endtask

    // Stops offering words until every owed result has been popped, then lets
    // the back end finish any frame-end peak update.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_reg(input logic [swah_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [swah_pkg::FACTOR_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == swah_pkg::REG_SMOOTH_SPEED)
            speed_reg = value;
        else if (idx == swah_pkg::REG_DECAY)
            decay_reg = value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Full-scale and zero bins in two short frames, the second one reversed so
    // the held levels both rise and decay.
    task automatic test_extreme_bins();
        send_bin('0, 1'b0);
        send_bin(swah_pkg::MAX24, 1'b0);
        send_bin(24'd1, 1'b0);
        send_bin(24'h800000, 1'b0);
        send_bin(swah_pkg::MAX24, 1'b1);
        send_bin(swah_pkg::MAX24, 1'b0);
        send_bin('0, 1'b0);
        send_bin(24'h7FFFFF, 1'b0);
        send_bin(24'd1, 1'b0);
        send_bin('0, 1'b1);
        wait_drained();
    endtask

    // Clamped factors, ignored register indexes, a zero gain reference, a
    // quotient overflow and zero factors.
    task automatic test_factor_extremes();
        write_reg(swah_pkg::REG_SMOOTH_SPEED, 17'h1FFFF);
        write_reg(swah_pkg::REG_DECAY, 17'h1FFFF);
        write_reg(REG_SPARE_2, '0);
        write_reg(REG_SPARE_3, 17'h1FFFF);
        // With the average jumping straight to the input the difference is
        // zero, so the frame peak and then the smoothed peak become zero.
        send_bin('0, 1'b0);
        send_bin(24'h123456, 1'b1);
        // Every quotient in this frame hits the zero-reference saturation.
        send_bin(24'hABCDEF, 1'b0);
        send_bin('0, 1'b1);
        wait_drained();
        // A tiny positive difference leaves a smoothed peak of one.
        write_reg(swah_pkg::REG_SMOOTH_SPEED, 17'd32768);
        write_reg(swah_pkg::REG_DECAY, '0);
        send_bin(24'hABCDF3, 1'b1);
        wait_drained();
        // Dividing a large difference by one overflows the quotient.
        write_reg(swah_pkg::REG_DECAY, 17'd65535);
        send_bin('0, 1'b1);
        wait_drained();
        write_reg(swah_pkg::REG_SMOOTH_SPEED, '0);
        send_bin(swah_pkg::MAX24, 1'b0);
        send_bin('0, 1'b1);
        wait_drained();
    endtask

    // One frame longer than the bin stores: the index wraps and the frame
    // peak keeps building until the frame finally ends.
    task automatic test_long_frame();
        write_reg(swah_pkg::REG_SMOOTH_SPEED, swah_pkg::SMOOTH_RESET);
        write_reg(swah_pkg::REG_DECAY, swah_pkg::DECAY_RESET);
        for (int b = 0; b < BIN_COUNT + 8; b++)
            send_bin(pick_magnitude(), b == BIN_COUNT + 7);
        wait_drained();
    endtask

    // The receiver stops for a long stretch while words keep coming, so both
    // internal queues fill and full must hold the sender off.
    task automatic test_full_stall();
        stall_len   <= 300;
        stall_token <= stall_token + 1;
        for (int b = 0; b < 40; b++)
            send_bin(pick_magnitude(), (b % 8) == 7);
        wait_drained();
    endtask

    // Random frames, mostly short, with an occasional early frame end. The
    // registers are reloaded at random every so often while the block is idle.
    task automatic test_random_frames(input int send_pct, input int recv_pct);
        int sent;
        int since_cfg;
        int frame_len;
        logic fe;
        sent = 0;
        since_cfg = 0;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        while (sent < PHASE_ITEMS)
        begin
            if (since_cfg >= ITEMS_PER_CFG)
            begin
                wait_drained();
                write_reg(swah_pkg::REG_SMOOTH_SPEED, pick_factor());
                write_reg(swah_pkg::REG_DECAY, pick_factor());
                since_cfg = 0;
            end
            if ($urandom_range(0, 9) == 0)
                frame_len = $urandom_range(17, 64);
            else
                frame_len = $urandom_range(1, 16);
            for (int b = 0; b < frame_len; b++)
            begin
                fe = (b == frame_len - 1) || ($urandom_range(0, 39) == 0);
                send_bin(pick_magnitude(), fe);
            end
            sent += frame_len;
            since_cfg += frame_len;
        end
        wait_drained();
    endtask

    // Receiver: decides pop on the falling edge, random or held off by a
    // requested stall.
    always @(negedge clk)
    begin
        if (stall_token != stall_seen)
        begin
            stall_seen = stall_token;
            stall_left = stall_len;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Checker: every word popped from the block is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        swah_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, %s %0d %h %0d",
                         $time, "actual bin, level, last", bin_index, level, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (bin_index !== want.bin_index)
                begin
                    $display("%0t ns: bin_index mismatch, expected %0d, actual %0d",
                             $time, want.bin_index, bin_index);
                    mismatch_count++;
                end
                if (level !== want.level)
                begin
                    $display("%0t ns: level mismatch on bin %0d, expected %h, actual %h",
                             $time, want.bin_index, want.level, level);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t ns: last mismatch on bin %0d, expected %0d, actual %0d",
                             $time, want.bin_index, want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends a hung run.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        magnitude = '0;
        frame_end = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        speed_reg     = swah_pkg::SMOOTH_RESET;
        decay_reg     = swah_pkg::DECAY_RESET;
        smoothed_peak = swah_pkg::PEAK_RESET;
        frame_peak    = '0;
        bin_count     = '0;
        for (int i = 0; i < BIN_COUNT; i++)
        begin
            avg_mem[i]  = '0;
            held_mem[i] = '0;
        end
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The block sweeps its stores after reset and holds full meanwhile;
        // the first word simply waits for it.
        test_extreme_bins();
        test_factor_extremes();
        test_long_frame();
        test_full_stall();
        test_random_frames(8, 69);
        test_random_frames(69, 8);
        test_random_frames(0, 0);
        wait_drained();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/swah_pkg.sv
rtl/swah_fifo.sv
rtl/swah_front.sv
rtl/swah_back.sv
rtl/spectral_whiten_autogain_hold_core.sv
sim/tb_top.sv
